FILE: hw/rtl/tmie_pkg.sv
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared types and constants for the tape machine execute core.
// ----------------------------------------------------------------------------
package tmie_pkg;

    localparam int TAPE_CELLS     = 30000;
    localparam int PROG_ADDR_BITS = 16;
    localparam int PTR_W          = $clog2(TAPE_CELLS);
    localparam int PC_W           = PROG_ADDR_BITS;
    localparam int CMD_W          = 3;
    localparam int TARGET_W       = 16;
    localparam int BYTE_W         = 8;

    localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_RIGHT = 3'd0,
        CMD_LEFT  = 3'd1,
        CMD_INC   = 3'd2,
        CMD_DEC   = 3'd3,
        CMD_OUT   = 3'd4,
        CMD_IN    = 3'd5,
        CMD_JZ    = 3'd6,
        CMD_JNZ   = 3'd7
    } cmd_t;

    // tape write port
    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } tape_wr_t;

endpackage

FILE: hw/rtl/tmie_ram.sv
// ----------------------------------------------------------------------------
// tmie_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/tmie_clear.sv
// ----------------------------------------------------------------------------
// tmie_clear
// Post-reset sweep writing zero to every tape cell.
// ----------------------------------------------------------------------------
module tmie_clear (
    input  logic               aclk,
    input  logic               aresetn,
    output logic               busy,
    output tmie_pkg::tape_wr_t wr
);
    import tmie_pkg::*;

    logic [PTR_W-1:0] count_reg, count_next;
    logic             busy_reg,  busy_next;

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        if (busy_reg) begin
            if (count_reg == LAST_CELL) begin
                busy_next = 1'b0;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b1;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy    = busy_reg;
    assign wr.en   = busy_reg;
    assign wr.addr = count_reg;
    assign wr.data = '0;

endmodule

FILE: hw/rtl/tmie_exec.sv
// ----------------------------------------------------------------------------
// tmie_exec
// Instruction pipeline: pointer update and tape read on accept, then
// read-modify-write of the cell, pc update and result register.
// ----------------------------------------------------------------------------
module tmie_exec (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 enable,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tmie_pkg::CMD_W-1:0]           s_command,
    input  logic [tmie_pkg::TARGET_W-1:0]        s_jump_target,
    input  logic [tmie_pkg::BYTE_W-1:0]          s_in_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_out_valid,
    output logic [tmie_pkg::BYTE_W-1:0]          m_out_byte,
    output logic [tmie_pkg::TARGET_W-1:0]        m_next_pc,
    output logic                                 rd_en,
    output logic [tmie_pkg::PTR_W-1:0]           rd_addr,
    input  logic [tmie_pkg::BYTE_W-1:0]          rd_data,
    output tmie_pkg::tape_wr_t                   wr
);
    import tmie_pkg::*;

    logic              accept, adv, fire;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;

    // execute stage (item waiting on its tape read)
    logic              s1_v_reg;
    cmd_t              s1_cmd_reg;
    logic [PC_W-1:0]   s1_target_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [PTR_W-1:0]  s1_addr_reg;
    logic              fwd_v_reg;
    logic [BYTE_W-1:0] fwd_val_reg;

    logic [PC_W-1:0]   pc_reg, pc_next;

    logic              m_v_reg;
    logic              m_outv_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [PC_W-1:0]   m_pc_reg;

    logic [BYTE_W-1:0] cell_val, wdata;
    logic              we, outv;
    logic [BYTE_W-1:0] outb;
    logic [PC_W-1:0]   pc_inc;

    assign adv     = !m_v_reg || m_ready;
    assign fire    = s1_v_reg && adv;
    assign s_ready = enable && (!s1_v_reg || adv);
    assign accept  = s_valid && s_ready;

    // pointer moves are resolved at accept time
    always_comb begin
        ptr_next = ptr_reg;
        case (cmd_t'(s_command))
            CMD_RIGHT: ptr_next = (ptr_reg == LAST_CELL) ? '0 : ptr_reg + 1'b1;
            CMD_LEFT:  ptr_next = (ptr_reg == '0) ? LAST_CELL : ptr_reg - 1'b1;
            default:   ptr_next = ptr_reg;
        endcase
    end

    assign rd_en   = accept;
    assign rd_addr = ptr_reg;

    // cell value: bypass the write that coincided with the read
    assign cell_val = fwd_v_reg ? fwd_val_reg : rd_data;
    assign pc_inc   = pc_reg + 1'b1;

    always_comb begin
        we      = 1'b0;
        wdata   = cell_val;
        outv    = 1'b0;
        outb    = '0;
        pc_next = pc_inc;
        case (s1_cmd_reg)
            CMD_INC: begin
                we    = 1'b1;
                wdata = cell_val + 1'b1;
            end
            CMD_DEC: begin
                we    = 1'b1;
                wdata = cell_val - 1'b1;
            end
            CMD_OUT: begin
                outv = 1'b1;
                outb = cell_val;
            end
            CMD_IN: begin
                we    = 1'b1;
                wdata = s1_byte_reg;
            end
            CMD_JZ: begin
                if (cell_val == '0) begin
                    pc_next = s1_target_reg + 1'b1;
                end
            end
            CMD_JNZ: begin
                if (cell_val != '0) begin
                    pc_next = s1_target_reg;
                end
            end
            default: ;
        endcase
    end

    assign wr.en   = fire && we;
    assign wr.addr = s1_addr_reg;
    assign wr.data = wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            pc_reg    <= '0;
            s1_v_reg  <= 1'b0;
            fwd_v_reg <= 1'b0;
            m_v_reg   <= 1'b0;
        end else begin
            if (accept) begin
                ptr_reg   <= ptr_next;
                s1_v_reg  <= 1'b1;
                fwd_v_reg <= fire && we && (s1_addr_reg == ptr_reg);
            end else if (fire) begin
                s1_v_reg  <= 1'b0;
            end
            if (fire) begin
                pc_reg  <= pc_next;
                m_v_reg <= 1'b1;
            end else if (m_ready) begin
                m_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg    <= cmd_t'(s_command);
            s1_target_reg <= PC_W'(s_jump_target);
            s1_byte_reg   <= s_in_byte;
            s1_addr_reg   <= ptr_reg;
            fwd_val_reg   <= wdata;
        end
        if (fire) begin
            m_outv_reg <= outv;
            m_byte_reg <= outb;
            m_pc_reg   <= pc_next;
        end
    end

    assign m_valid     = m_v_reg;
    assign m_out_valid = m_outv_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_next_pc   = TARGET_W'(m_pc_reg);

endmodule

FILE: hw/rtl/tape_machine_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_execute_core
// Execute stage of a byte-tape machine: one decoded instruction per
// transaction in, one result transaction out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_valid/s_ready): command, jump_target and in_byte.
//  - Output channel (m_valid/m_ready): out_valid/out_byte for the output
//    command (out_byte is zero otherwise) and next_pc for the fetch unit.
//  - Pipeline: m_valid is registered; each input transaction passes through
//    the execute stage, then the output register.
//  - Throughput: one transaction per cycle while m_ready stays high. The
//    tape lives in a block RAM with a registered read; the pointer is
//    updated on accept and the cell read-modify-write happens in the execute
//    stage, with a bypass when the next instruction reads the cell just written.
//  - Reset: pointer and pc go to zero; then a clearing pass writes zero to
//    all TAPE_CELLS cells, one per cycle, during which s_ready is held low.
//  - Receiver stall: the output register holds its result; one further
//    instruction may be accepted and waits in the execute stage, after
//    which s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module tape_machine_instruction_execute_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmie_pkg::CMD_W-1:0]    s_command,
    input  logic [tmie_pkg::TARGET_W-1:0] s_jump_target,
    input  logic [tmie_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_out_valid,
    output logic [tmie_pkg::BYTE_W-1:0]   m_out_byte,
    output logic [tmie_pkg::TARGET_W-1:0] m_next_pc
);
    import tmie_pkg::*;

    logic              clr_busy;
    tape_wr_t          clr_wr, exe_wr, ram_wr;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // clearing pass after reset
    tmie_clear u_clear (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (clr_busy),
        .wr      (clr_wr)
    );

    // instruction pipeline; held off while the tape is being cleared
    tmie_exec u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (!clr_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_jump_target (s_jump_target),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_valid   (m_out_valid),
        .m_out_byte    (m_out_byte),
        .m_next_pc     (m_next_pc),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr            (exe_wr)
    );

    // the sweep owns the write port until it finishes
    assign ram_wr = clr_busy ? clr_wr : exe_wr;

    tmie_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .aclk  (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

endmodule
